>>> design/rcb_pkg.sv
// rcb_pkg: shared types and codes of the rotating colour-key blitter
// holds the controller state type, command/status structs and field codes
// no dependencies
package rcb_pkg;

   // input operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   // draw mode codes
   localparam logic [1:0] MODE_FILL  = 2'd0;
   localparam logic [1:0] MODE_COPY  = 2'd1;
   localparam logic [1:0] MODE_KEYED = 2'd2;

   // rotation codes
   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   // configuration register indexes
   localparam logic [2:0] REG_DRAW_MODE     = 3'd0;
   localparam logic [2:0] REG_ROTATION      = 3'd1;
   localparam logic [2:0] REG_DEST_X        = 3'd2;
   localparam logic [2:0] REG_DEST_Y        = 3'd3;
   localparam logic [2:0] REG_SPRITE_WIDTH  = 3'd4;
   localparam logic [2:0] REG_SPRITE_HEIGHT = 3'd5;
   localparam logic [2:0] REG_KEY_COLOR     = 3'd6;
   localparam logic [2:0] REG_FILL_COLOR    = 3'd7;

   // fixed field widths
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int PIX_INDEX_W  = 14;
   localparam int COLOR_W      = 16;
   localparam int OFFSET_W     = 17;
   localparam int SRC_INDEX_W  = 17;
   localparam int COUNT_W      = 9;
   localparam int COORD_W      = 11;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INDEX,
      ST_QUOT,
      ST_REM,
      ST_READ,
      ST_EMIT
   } ctrl_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load_write;
      logic step_start;
      logic calc_index;
      logic calc_quot;
      logic calc_rem;
      logic read_store;
      logic emit;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

>>> design/rcb_ram.sv
// rcb_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module rcb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, data held between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/rcb_ctrl.sv
// rcb_ctrl: sequencer of the blitter, one item at a time
// depends on rcb_pkg for state, command and status types
module rcb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_operation,
   output logic                  req_stall,
   input  rcb_pkg::dp_status_type status,
   output rcb_pkg::ctrl_cmd_type  cmd
);

   rcb_pkg::ctrl_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rcb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         rcb_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_operation == rcb_pkg::OP_LOAD) begin
                  cmd.load_write = 1'b1;
               end else begin
                  cmd.step_start = 1'b1;
                  state_in       = rcb_pkg::ST_INDEX;
               end
            end
         end
         rcb_pkg::ST_INDEX: begin
            cmd.calc_index = 1'b1;
            state_in       = rcb_pkg::ST_QUOT;
         end
         rcb_pkg::ST_QUOT: begin
            cmd.calc_quot = 1'b1;
            state_in      = rcb_pkg::ST_REM;
         end
         rcb_pkg::ST_REM: begin
            cmd.calc_rem = 1'b1;
            state_in     = rcb_pkg::ST_READ;
         end
         rcb_pkg::ST_READ: begin
            cmd.read_store = 1'b1;
            state_in       = rcb_pkg::ST_EMIT;
         end
         rcb_pkg::ST_EMIT: begin
            // hold until the output register can take the transaction
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = rcb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rcb_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> design/rcb_datapath.sv
// rcb_datapath: configuration registers, blit counters, address arithmetic,
// sprite store and output register; depends on rcb_pkg and rcb_ram
module rcb_datapath #(
   parameter int SCREEN_WIDTH  = 384,
   parameter int SCREEN_HEIGHT = 216,
   parameter int SPRITE_WORDS  = 16384
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rcb_pkg::ctrl_cmd_type                 cmd,
   output rcb_pkg::dp_status_type                status,
   input  logic [rcb_pkg::PIX_INDEX_W-1:0]       req_pixel_index,
   input  logic [rcb_pkg::COLOR_W-1:0]           req_pixel_color,
   input  logic                                  csr_write_enable,
   input  logic [rcb_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [rcb_pkg::CSR_DATA_W-1:0]        csr_write_data,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic                                  rsp_write_valid,
   output logic [rcb_pkg::OFFSET_W-1:0]          rsp_vram_offset,
   output logic [rcb_pkg::COLOR_W-1:0]           rsp_write_color,
   output logic                                  rsp_last
);

   localparam int AW      = $clog2(SPRITE_WORDS);
   localparam int IW      = rcb_pkg::SRC_INDEX_W;
   localparam int CW      = rcb_pkg::COUNT_W;
   localparam int XW      = rcb_pkg::COORD_W;
   // reciprocal for the store wrap: q estimate is exact or one short
   localparam int RECIP   = (1 << IW) / SPRITE_WORDS;
   localparam int RW      = $clog2(RECIP + 1);
   localparam int PW      = IW + RW;
   localparam int FULL_W  = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT);
   localparam int OFF_W   = (FULL_W > rcb_pkg::OFFSET_W) ? FULL_W : rcb_pkg::OFFSET_W;

   // configuration registers
   logic [1:0]  draw_mode_ff;
   logic [1:0]  rotation_ff;
   logic [9:0]  dest_x_ff;
   logic [8:0]  dest_y_ff;
   logic [8:0]  sprite_width_ff;
   logic [7:0]  sprite_height_ff;
   logic [15:0] key_color_ff;
   logic [15:0] fill_color_ff;

   // blit state
   logic [CW-1:0] column_count_ff, column_count_in;
   logic [CW-1:0] row_count_ff, row_count_in;
   logic          blit_active_ff, blit_active_in;

   // per-transaction working registers
   logic [CW-1:0]    cur_i_ff, cur_j_ff;
   logic [IW-1:0]    src_index_ff;
   logic [RW-1:0]    quot_ff;
   logic [IW-1:0]    rem_ff;
   logic             pos_ok_ff;
   logic [OFF_W-1:0] offset_ff;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_write_valid_ff;
   logic [rcb_pkg::OFFSET_W-1:0]  rsp_vram_offset_ff;
   logic [rcb_pkg::COLOR_W-1:0]   rsp_write_color_ff;
   logic                          rsp_last_ff;

   // blit geometry
   logic [CW-1:0] cols, rows, clip;
   logic          empty_blit;

   always_comb begin
      if (draw_mode_ff == rcb_pkg::MODE_FILL || !rotation_ff[0]) begin
         cols = sprite_width_ff;
         rows = {1'b0, sprite_height_ff};
      end else begin
         cols = {1'b0, sprite_height_ff};
         rows = sprite_width_ff;
      end
      clip       = dest_y_ff[8] ? CW'(~dest_y_ff + 9'd1) : '0;
      empty_blit = !blit_active_ff && (cols == '0 || clip >= rows);
   end

   // configuration writes, any write aborts a running blit
   always_ff @(posedge clock) begin
      if (reset) begin
         draw_mode_ff     <= '0;
         rotation_ff      <= '0;
         dest_x_ff        <= '0;
         dest_y_ff        <= '0;
         sprite_width_ff  <= '0;
         sprite_height_ff <= '0;
         key_color_ff     <= '0;
         fill_color_ff    <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            rcb_pkg::REG_DRAW_MODE:     draw_mode_ff     <= csr_write_data[1:0];
            rcb_pkg::REG_ROTATION:      rotation_ff      <= csr_write_data[1:0];
            rcb_pkg::REG_DEST_X:        dest_x_ff        <= csr_write_data[9:0];
            rcb_pkg::REG_DEST_Y:        dest_y_ff        <= csr_write_data[8:0];
            rcb_pkg::REG_SPRITE_WIDTH:  sprite_width_ff  <= csr_write_data[8:0];
            rcb_pkg::REG_SPRITE_HEIGHT: sprite_height_ff <= csr_write_data[7:0];
            rcb_pkg::REG_KEY_COLOR:     key_color_ff     <= csr_write_data;
            rcb_pkg::REG_FILL_COLOR:    fill_color_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // start of a step: resume the blit or open a new one at the clip row
   always_ff @(posedge clock) begin
      if (cmd.step_start) begin
         cur_i_ff <= blit_active_ff ? column_count_ff : '0;
         cur_j_ff <= blit_active_ff ? row_count_ff : clip;
      end
   end

   // source coordinates of the rotated sprite, screen position
   logic [CW-1:0]    src_row, src_col;
   logic [XW-1:0]    sx, sy;
   logic             pos_ok;
   logic [OFF_W-1:0] offset;

   always_comb begin
      unique case (rotation_ff)
         rcb_pkg::ROT_0: begin
            src_row = cur_j_ff;
            src_col = cur_i_ff;
         end
         rcb_pkg::ROT_90: begin
            src_row = CW'({1'b0, sprite_height_ff} - 9'd1 - cur_i_ff);
            src_col = cur_j_ff;
         end
         rcb_pkg::ROT_180: begin
            src_row = CW'({1'b0, sprite_height_ff} - 9'd1 - cur_j_ff);
            src_col = CW'(sprite_width_ff - 9'd1 - cur_i_ff);
         end
         rcb_pkg::ROT_270: begin
            src_row = cur_i_ff;
            src_col = CW'(sprite_width_ff - 9'd1 - cur_j_ff);
         end
         default: begin
            src_row = cur_j_ff;
            src_col = cur_i_ff;
         end
      endcase
      sx     = XW'({{(XW-10){dest_x_ff[9]}}, dest_x_ff} + {2'b00, cur_i_ff});
      sy     = XW'({{(XW-9){dest_y_ff[8]}}, dest_y_ff} + {2'b00, cur_j_ff});
      pos_ok = !sx[XW-1] && (sx < XW'(SCREEN_WIDTH))
            && !sy[XW-1] && (sy < XW'(SCREEN_HEIGHT));
      offset = OFF_W'(sy[XW-2:0]) * OFF_W'(SCREEN_WIDTH) + OFF_W'(sx[XW-2:0]);
   end

   // store index, then wrap into the store depth by reciprocal multiply
   always_ff @(posedge clock) begin
      if (cmd.calc_index) begin
         src_index_ff <= IW'(src_row * sprite_width_ff) + IW'(src_col);
         pos_ok_ff    <= pos_ok;
         offset_ff    <= offset;
      end
      if (cmd.calc_quot) begin
         quot_ff <= RW'((PW'(src_index_ff) * PW'(RECIP)) >> IW);
      end
      if (cmd.calc_rem) begin
         rem_ff <= IW'(PW'(src_index_ff) - PW'(quot_ff) * PW'(SPRITE_WORDS));
      end
   end

   // final correction of the remainder gives the read address
   logic [IW-1:0] rem_fixed;
   assign rem_fixed = (rem_ff >= IW'(SPRITE_WORDS)) ? IW'(rem_ff - IW'(SPRITE_WORDS)) : rem_ff;

   // sprite store, loads beyond the depth are dropped
   logic                        load_en;
   logic [rcb_pkg::COLOR_W-1:0] store_rd_data;

   assign load_en = cmd.load_write && (32'(req_pixel_index) < 32'(SPRITE_WORDS));

   rcb_ram #(
      .WIDTH (rcb_pkg::COLOR_W),
      .DEPTH (SPRITE_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (AW'(req_pixel_index)),
      .wr_data (req_pixel_color),
      .rd_en   (cmd.read_store),
      .rd_addr (AW'(rem_fixed)),
      .rd_data (store_rd_data)
   );

   // pixel colour, key test and counter advance
   logic [rcb_pkg::COLOR_W-1:0] color;
   logic                        write_ok;
   logic [CW:0]                 next_i, next_j;
   logic                        col_done, blit_done;

   always_comb begin
      color    = (draw_mode_ff == rcb_pkg::MODE_FILL) ? fill_color_ff : store_rd_data;
      write_ok = pos_ok_ff && !(draw_mode_ff[1] && color == key_color_ff);
      next_j   = {1'b0, cur_j_ff} + 10'd1;
      next_i   = {1'b0, cur_i_ff} + 10'd1;
      col_done = next_j >= {1'b0, rows};
      blit_done = col_done && (next_i >= {1'b0, cols});

      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      blit_active_in  = blit_active_ff;
      if (csr_write_enable) begin
         blit_active_in = 1'b0;
      end else if (cmd.emit && !empty_blit) begin
         if (col_done) begin
            row_count_in    = clip;
            column_count_in = next_i[CW-1:0];
         end else begin
            row_count_in    = next_j[CW-1:0];
            column_count_in = cur_i_ff;
         end
         blit_active_in = !blit_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
         blit_active_ff  <= 1'b0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         blit_active_ff  <= blit_active_in;
      end
   end

   // output register
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         if (empty_blit) begin
            rsp_write_valid_ff <= 1'b0;
            rsp_vram_offset_ff <= '0;
            rsp_write_color_ff <= '0;
            rsp_last_ff        <= 1'b1;
         end else begin
            rsp_write_valid_ff <= write_ok;
            rsp_vram_offset_ff <= write_ok ? rcb_pkg::OFFSET_W'(offset_ff) : '0;
            rsp_write_color_ff <= write_ok ? color : '0;
            rsp_last_ff        <= blit_done;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_write_valid = rsp_write_valid_ff;
   assign rsp_vram_offset = rsp_vram_offset_ff;
   assign rsp_write_color = rsp_write_color_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

>>> design/rotating_color_key_blitter_top.sv
// rotating_color_key_blitter_top: colour-keyed sprite blitter with rotation
// depends on rcb_pkg, rcb_ctrl, rcb_datapath (and rcb_ram below it)
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  operation, pixel_index, pixel_color
//   rsp      out        rsp_valid / rsp_stall  write_valid, vram_offset, write_color, last
//   csr      in         csr_write_enable       csr_index, csr_write_data
//
// a load transaction writes the store when it is accepted; a step passes from
// acceptance to the result register through index multiply, wrap quotient, wrap
// remainder, store read and emit, as the sequencer walks the sprite store read path
// reset clears configuration, counters and handshake state; the store is not
// cleared and needs no clearing pass
// a stalled result holds the sequencer in its emit step; new transactions are
// taken as soon as the result has moved into the output register
module rotating_color_key_blitter_top #(
   parameter int SCREEN_WIDTH  = 384,
   parameter int SCREEN_HEIGHT = 216,
   parameter int SPRITE_WORDS  = 16384
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic [rcb_pkg::PIX_INDEX_W-1:0]     req_pixel_index,
   input  logic [rcb_pkg::COLOR_W-1:0]         req_pixel_color,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_write_valid,
   output logic [rcb_pkg::OFFSET_W-1:0]        rsp_vram_offset,
   output logic [rcb_pkg::COLOR_W-1:0]         rsp_write_color,
   output logic                                rsp_last,
   input  logic                                csr_write_enable,
   input  logic [rcb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rcb_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   rcb_pkg::ctrl_cmd_type  cmd;
   rcb_pkg::dp_status_type status;

   // sequencer
   rcb_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd)
   );

   // datapath
   rcb_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .SPRITE_WORDS  (SPRITE_WORDS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_pixel_index  (req_pixel_index),
      .req_pixel_color  (req_pixel_color),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_write_valid  (rsp_write_valid),
      .rsp_vram_offset  (rsp_vram_offset),
      .rsp_write_color  (rsp_write_color),
      .rsp_last         (rsp_last)
   );

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for rotating_color_key_blitter_top, with a cycle-free predictor
// of the blit walk, a directed table, then random blits under three stall patterns
// depends on rcb_pkg and the blitter rtl
module tb;
   import rcb_pkg::*;

   localparam int SCREEN_W = 384;
   localparam int SCREEN_H = 216;
   localparam int STORE_WORDS = 16384;
   // the fourth draw mode code, which behaves as keyed copy
   localparam logic [1:0] MODE_THREE = 2'd3;
   localparam int DRAIN_CYCLES = 12;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD = 80;

   typedef struct packed {
      logic                write_valid;
      logic [OFFSET_W-1:0] vram_offset;
      logic [COLOR_W-1:0]  write_color;
      logic                last;
   } fb_write_t;

   typedef enum logic [1:0] {ROW_CSR, ROW_LOAD, ROW_STEP} row_kind_e;

   typedef struct {
      row_kind_e              kind;
      logic [PIX_INDEX_W-1:0] addr;
      logic [COLOR_W-1:0]     data;
      bit                     checked;
      fb_write_t              want;
   } stim_row_t;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_operation;
   logic [PIX_INDEX_W-1:0] req_pixel_index;
   logic [COLOR_W-1:0]     req_pixel_color;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_write_valid;
   logic [OFFSET_W-1:0]    rsp_vram_offset;
   logic [COLOR_W-1:0]     rsp_write_color;
   logic                   rsp_last;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   // predictor copy of the registers and walk state
   logic [1:0]        sh_mode;
   logic [1:0]        sh_rot;
   logic signed [9:0] sh_dest_x;
   logic signed [8:0] sh_dest_y;
   logic [8:0]        sh_width;
   logic [7:0]        sh_height;
   logic [15:0]       sh_key;
   logic [15:0]       sh_fill;
   logic [8:0]        col_cnt;
   logic [8:0]        row_cnt;
   bit                blit_busy;
   logic [15:0]       sprite_mem [STORE_WORDS];
   bit                pix_written [STORE_WORDS];

   fb_write_t pending_fb_writes [$];
   stim_row_t directed_rows [$];

   // driver side bookkeeping
   bit        row_checked;
   fb_write_t row_want;
   bit        needs_drain;
   int        items_sent;
   int        req_idle_pct;
   int        rsp_idle_pct;
   bit        long_hold_req;
   int        hold_left;
   int        quiet_cycles;
   int        fail_count;
   int        n_loads;
   int        n_steps;
   int        n_fb_writes;
   int        n_blits;
   int        n_reg_writes;

   rotating_color_key_blitter_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_pixel_index  (req_pixel_index),
      .req_pixel_color  (req_pixel_color),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_write_valid  (rsp_write_valid),
      .rsp_vram_offset  (rsp_vram_offset),
      .rsp_write_color  (rsp_write_color),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // drawn columns and rows, and the rows skipped above the screen
   function automatic void blit_shape(output int unsigned cols, output int unsigned rows,
                                      output int unsigned clip);
      if (sh_mode == MODE_FILL || !sh_rot[0]) begin
         cols = sh_width;
         rows = sh_height;
      end else begin
         cols = sh_height;
         rows = sh_width;
      end
      clip = (sh_dest_y < 0) ? -int'(sh_dest_y) : 0;
   endfunction

   // store word read for destination column i, row j
   function automatic int unsigned src_word(int unsigned i, int unsigned j);
      int unsigned w;
      int unsigned h;
      int unsigned idx;
      w = sh_width;
      h = sh_height;
      case (sh_rot)
         ROT_0:   idx = j * w + i;
         ROT_90:  idx = (h - 1 - i) * w + j;
         ROT_180: idx = (h - 1 - j) * w + (w - 1 - i);
         default: idx = i * w + (w - 1 - j);
      endcase
      return idx % STORE_WORDS;
   endfunction

   // one step of the blit: frame-buffer write it reports, counters advanced
   function automatic fb_write_t predict_fb_write();
      int unsigned cols;
      int unsigned rows;
      int unsigned clip;
      int unsigned i;
      int unsigned j;
      int          sx;
      int          sy;
      logic [15:0] color;
      bit          on_screen;
      bit          done;
      blit_shape(cols, rows, clip);
      if (!blit_busy) begin
         if (cols == 0 || clip >= rows)
            return fb_write_t'{1'b0, '0, '0, 1'b1};
         col_cnt = '0;
         row_cnt = clip[8:0];
         blit_busy = 1'b1;
      end
      i = col_cnt;
      j = row_cnt;
      color = (sh_mode == MODE_FILL) ? sh_fill : sprite_mem[src_word(i, j)];
      sx = int'(sh_dest_x) + int'(i);
      sy = int'(sh_dest_y) + int'(j);
      on_screen = sx >= 0 && sx < SCREEN_W && sy >= 0 && sy < SCREEN_H;
      // upper mode bit selects keying, so mode three keys as well
      if (sh_mode[1] && color == sh_key)
         on_screen = 1'b0;
      // column-major walk, rows inner
      done = 1'b0;
      j++;
      if (j >= rows) begin
         j = clip;
         i++;
         if (i >= cols) begin
            done = 1'b1;
            blit_busy = 1'b0;
         end
      end
      col_cnt = i[8:0];
      row_cnt = j[8:0];
      if (on_screen)
         return fb_write_t'{1'b1, OFFSET_W'(sy * SCREEN_W + sx), color, done};
      return fb_write_t'{1'b0, '0, '0, done};
   endfunction

   // store word that the next step will read, if any
   function automatic void next_src_word(output bit reads, output int unsigned word);
      int unsigned cols;
      int unsigned rows;
      int unsigned clip;
      blit_shape(cols, rows, clip);
      reads = 1'b0;
      word = 0;
      if (sh_mode == MODE_FILL)
         return;
      if (!blit_busy) begin
         if (cols == 0 || clip >= rows)
            return;
         word = src_word(0, clip);
      end else begin
         word = src_word(col_cnt, row_cnt);
      end
      reads = 1'b1;
   endfunction

   // register write: any write aborts the running blit
   function automatic void apply_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_DRAW_MODE:     sh_mode = data[1:0];
         REG_ROTATION:      sh_rot = data[1:0];
         REG_DEST_X:        sh_dest_x = data[9:0];
         REG_DEST_Y:        sh_dest_y = data[8:0];
         REG_SPRITE_WIDTH:  sh_width = data[8:0];
         REG_SPRITE_HEIGHT: sh_height = data[7:0];
         REG_KEY_COLOR:     sh_key = data;
         default:           sh_fill = data;
      endcase
      blit_busy = 1'b0;
   endfunction

   task automatic check_fb_write(fb_write_t want);
      if (rsp_write_valid !== want.write_valid) begin
         $error("write_valid: expected %0d, got %0d", want.write_valid, rsp_write_valid);
         fail_count++;
      end
      if (rsp_vram_offset !== want.vram_offset) begin
         $error("vram_offset: expected %0d, got %0d", want.vram_offset, rsp_vram_offset);
         fail_count++;
      end
      if (rsp_write_color !== want.write_color) begin
         $error("write_color: expected %h, got %h", want.write_color, rsp_write_color);
         fail_count++;
      end
      if (rsp_last !== want.last) begin
         $error("last: expected %0d, got %0d", want.last, rsp_last);
         fail_count++;
      end
   endtask

   // monitor: results first, then register writes and accepted transactions
   always @(posedge clock) begin : monitor
      fb_write_t want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_fb_writes.size() == 0) begin
               $error("result with nothing expected: valid %0d offset %0d colour %h last %0d",
                      rsp_write_valid, rsp_vram_offset, rsp_write_color, rsp_last);
               fail_count++;
            end else begin
               want = pending_fb_writes.pop_front();
               check_fb_write(want);
            end
         end
         if (csr_write_enable) begin
            apply_reg(csr_index, csr_write_data);
            n_reg_writes++;
         end
         if (req_valid && !req_stall) begin
            if (req_operation == OP_LOAD) begin
               sprite_mem[req_pixel_index] = req_pixel_color;
               pix_written[req_pixel_index] = 1'b1;
               n_loads++;
            end else begin
               want = predict_fb_write();
               if (row_checked)
                  want = row_want;
               pending_fb_writes.push_back(want);
               n_steps++;
               n_fb_writes += want.write_valid;
               n_blits += want.last;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // result side: random stall, plus a long hold-off when asked
   initial begin
      rsp_stall = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left != 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD - 1;
            rsp_stall = 1'b1;
         end else begin
            rsp_stall = ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   // offer one transaction and wait for it to be taken; entered and left at a falling edge
   task automatic send_item(logic op, logic [PIX_INDEX_W-1:0] idx, logic [COLOR_W-1:0] color,
                            bit checked, fb_write_t want);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_operation = op;
      req_pixel_index = idx;
      req_pixel_color = color;
      row_checked = checked;
      row_want = want;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
      needs_drain = 1'b1;
   endtask

   // random pixel colour, hitting the key colour often in keyed modes
   function automatic logic [COLOR_W-1:0] pick_color();
      if (sh_mode[1] && $urandom_range(3) == 0)
         return sh_key;
      return COLOR_W'($urandom);
   endfunction

   task automatic send_load(logic [PIX_INDEX_W-1:0] idx, logic [COLOR_W-1:0] color);
      send_item(OP_LOAD, idx, color, 1'b0, '0);
   endtask

   // a step, preceded by a load if it would read a word never written
   task automatic send_step(bit checked, fb_write_t want);
      bit          reads;
      int unsigned word;
      next_src_word(reads, word);
      if (reads && !pix_written[word])
         send_load(word[PIX_INDEX_W-1:0], pick_color());
      send_item(OP_STEP, PIX_INDEX_W'($urandom), COLOR_W'($urandom), checked, want);
   endtask

   // let every result arrive, then allow for a load still in flight
   task automatic wait_quiet();
      req_valid = 1'b0;
      while (pending_fb_writes.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      needs_drain = 1'b0;
   endtask

   task automatic program_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      if (needs_drain)
         wait_quiet();
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   function automatic stim_row_t row(row_kind_e kind, logic [PIX_INDEX_W-1:0] addr = '0,
                                     logic [COLOR_W-1:0] data = '0, bit checked = 1'b0,
                                     fb_write_t want = '0);
      stim_row_t r;
      r.kind = kind;
      r.addr = addr;
      r.data = data;
      r.checked = checked;
      r.want = want;
      return r;
   endfunction

   // one random blit: registers, sprite loads, then its steps (maybe cut short or overrun)
   task automatic random_blit(bit pressure);
      int          w;
      int          h;
      int          dx;
      int          dy;
      int          n;
      int          total;
      int unsigned cols;
      int unsigned rows;
      int unsigned clip;
      case ($urandom_range(19))
         0: begin
            w = $urandom_range(0, 384);
            h = $urandom_range(0, 216);
         end
         1: begin
            w = 384;
            h = 216;
         end
         2: begin
            w = $urandom_range(0, 1);
            h = $urandom_range(0, 2);
         end
         default: begin
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 6);
         end
      endcase
      case ($urandom_range(9))
         0:       dx = int'($urandom_range(0, 1023)) - 512;
         1:       dx = 378 + int'($urandom_range(0, 8));
         2:       dx = -int'($urandom_range(1, 8));
         default: dx = $urandom_range(0, 12);
      endcase
      case ($urandom_range(9))
         0:       dy = int'($urandom_range(0, 511)) - 256;
         1:       dy = 210 + int'($urandom_range(0, 8));
         2:       dy = -int'($urandom_range(1, 6));
         default: dy = $urandom_range(0, 8);
      endcase
      if (pressure) begin
         w = $urandom_range(4, 8);
         h = $urandom_range(4, 8);
         dx = $urandom_range(0, 12);
         dy = $urandom_range(0, 8);
      end
      if (pressure || $urandom_range(3) != 0)
         program_reg(REG_DRAW_MODE, CSR_DATA_W'($urandom_range(3)));
      if (pressure || $urandom_range(3) != 0)
         program_reg(REG_ROTATION, CSR_DATA_W'($urandom_range(3)));
      if (pressure || $urandom_range(3) != 0)
         program_reg(REG_DEST_X, {6'd0, 10'(dx)});
      if (pressure || $urandom_range(3) != 0)
         program_reg(REG_DEST_Y, {7'd0, 9'(dy)});
      if ($urandom_range(3) == 0)
         program_reg(REG_KEY_COLOR, CSR_DATA_W'($urandom));
      if ($urandom_range(3) == 0)
         program_reg(REG_FILL_COLOR, CSR_DATA_W'($urandom));
      program_reg(REG_SPRITE_WIDTH, {7'd0, 9'(w)});
      program_reg(REG_SPRITE_HEIGHT, {8'd0, 8'(h)});

      // small sprites are loaded whole before the blit, except in fill mode
      if (sh_mode != MODE_FILL && w * h <= 64)
         for (int k = 0; k < w * h; k++)
            send_load(PIX_INDEX_W'(k), pick_color());

      blit_shape(cols, rows, clip);
      total = (cols == 0 || clip >= rows) ? 1 : int'(cols * (rows - clip));
      if (pressure)
         n = total;
      else if (total > 40)
         n = $urandom_range(1, 12);
      else
         case ($urandom_range(6))
            0:       n = $urandom_range(1, total);
            1:       n = total + int'($urandom_range(1, 3));
            default: n = total;
         endcase
      if (pressure)
         long_hold_req = 1'b1;
      repeat (n) begin
         if ($urandom_range(11) == 0)
            send_load(PIX_INDEX_W'($urandom), COLOR_W'($urandom));
         send_step(1'b0, '0);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_LOAD;
      req_pixel_index = '0;
      req_pixel_color = '0;
      csr_write_enable = 1'b0;
      csr_index = REG_DRAW_MODE;
      csr_write_data = '0;
      row_checked = 1'b0;
      row_want = '0;
      needs_drain = 1'b0;
      long_hold_req = 1'b0;
      items_sent = 0;
      fail_count = 0;
      quiet_cycles = 0;
      req_idle_pct = 35;
      rsp_idle_pct = 49;
      {n_loads, n_steps, n_fb_writes, n_blits, n_reg_writes} = '0;
      sh_mode = MODE_FILL;
      sh_rot = ROT_0;
      {sh_dest_x, sh_dest_y, sh_width, sh_height, sh_key, sh_fill} = '0;
      col_cnt = '0;
      row_cnt = '0;
      blit_busy = 1'b0;
      foreach (pix_written[k])
         pix_written[k] = 1'b0;

      // directed transactions; typed results only where obvious
      directed_rows = '{
         // empty blit straight after reset
         row(ROW_STEP, 0, 0, 1'b1, fb_write_t'{1'b0, 17'd0, 16'h0000, 1'b1}),
         row(ROW_CSR, REG_FILL_COLOR, 16'hFFFF),
         row(ROW_CSR, REG_SPRITE_WIDTH, 16'd1),
         row(ROW_CSR, REG_SPRITE_HEIGHT, 16'd1),
         row(ROW_STEP, 0, 0, 1'b1, fb_write_t'{1'b1, 17'd0, 16'hFFFF, 1'b1}),
         // bottom-right pixel of the screen
         row(ROW_CSR, REG_DEST_X, 16'd383),
         row(ROW_CSR, REG_DEST_Y, 16'd215),
         row(ROW_STEP, 0, 0, 1'b1, fb_write_t'{1'b1, 17'd82943, 16'hFFFF, 1'b1}),
         // most negative and most positive column: suppressed
         row(ROW_CSR, REG_DEST_X, 16'h0200),
         row(ROW_STEP, 0, 0, 1'b1, fb_write_t'{1'b0, 17'd0, 16'h0000, 1'b1}),
         row(ROW_CSR, REG_DEST_X, 16'd511),
         row(ROW_STEP, 0, 0, 1'b1, fb_write_t'{1'b0, 17'd0, 16'h0000, 1'b1}),
         // every row clipped away
         row(ROW_CSR, REG_DEST_Y, 16'h0100),
         row(ROW_STEP, 0, 0, 1'b1, fb_write_t'{1'b0, 17'd0, 16'h0000, 1'b1}),
         // full-size fill with all but the last row clipped, cut short by a write
         row(ROW_CSR, REG_DEST_X, 16'd0),
         row(ROW_CSR, REG_DEST_Y, 16'h0129),
         row(ROW_CSR, REG_SPRITE_WIDTH, 16'd384),
         row(ROW_CSR, REG_SPRITE_HEIGHT, 16'd216),
         row(ROW_CSR, REG_FILL_COLOR, 16'h0000),
         row(ROW_STEP),
         row(ROW_STEP),
         row(ROW_STEP),
         // sprite words, top index included
         row(ROW_LOAD, 14'd0, 16'h0000),
         row(ROW_LOAD, 14'd1, 16'hFFFF),
         row(ROW_LOAD, 14'd2, 16'h1234),
         row(ROW_LOAD, 14'd3, 16'hABCD),
         row(ROW_LOAD, 14'd16383, 16'h5555),
         // copy, ninety degrees
         row(ROW_CSR, REG_DRAW_MODE, 16'(MODE_COPY)),
         row(ROW_CSR, REG_DEST_Y, 16'd0),
         row(ROW_CSR, REG_SPRITE_WIDTH, 16'd2),
         row(ROW_CSR, REG_SPRITE_HEIGHT, 16'd2),
         row(ROW_CSR, REG_ROTATION, 16'(ROT_90)),
         row(ROW_STEP),
         row(ROW_STEP),
         row(ROW_STEP),
         row(ROW_STEP),
         // keyed, two-seventy degrees on a non-square sprite
         row(ROW_CSR, REG_DRAW_MODE, 16'(MODE_KEYED)),
         row(ROW_CSR, REG_KEY_COLOR, 16'hFFFF),
         row(ROW_CSR, REG_ROTATION, 16'(ROT_270)),
         row(ROW_CSR, REG_SPRITE_HEIGHT, 16'd1),
         row(ROW_STEP),
         row(ROW_STEP),
         // mode three keys like keyed copy, one-eighty degrees
         row(ROW_CSR, REG_DRAW_MODE, 16'(MODE_THREE)),
         row(ROW_CSR, REG_ROTATION, 16'(ROT_180)),
         row(ROW_CSR, REG_KEY_COLOR, 16'h0000),
         row(ROW_STEP),
         row(ROW_STEP),
         // fill ignores rotation
         row(ROW_CSR, REG_DRAW_MODE, 16'(MODE_FILL)),
         row(ROW_CSR, REG_ROTATION, 16'(ROT_90)),
         row(ROW_CSR, REG_SPRITE_WIDTH, 16'd3),
         row(ROW_CSR, REG_FILL_COLOR, 16'h07E0),
         row(ROW_STEP),
         row(ROW_STEP),
         row(ROW_STEP)
      };

      // synchronous reset, once
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[k])
         case (directed_rows[k].kind)
            ROW_CSR:  program_reg(directed_rows[k].addr[CSR_INDEX_W-1:0], directed_rows[k].data);
            ROW_LOAD: send_load(directed_rows[k].addr, directed_rows[k].data);
            default:  send_step(directed_rows[k].checked, directed_rows[k].want);
         endcase

      // random blits: sender lighter than receiver, then swapped, then no idling
      random_blit(1'b1);
      while (items_sent < 300)
         random_blit(1'b0);
      req_idle_pct = 49;
      rsp_idle_pct = 35;
      random_blit(1'b1);
      while (items_sent < 600)
         random_blit(1'b0);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      while (items_sent < 900)
         random_blit(1'b0);

      wait_quiet();
      $display("covered %0d sprite loads and %0d blit steps (%0d frame writes, %0d blits ended)",
               n_loads, n_steps, n_fb_writes, n_blits);
      $display("across %0d register writes, three stall patterns and long result hold-offs",
               n_reg_writes);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

>>> sim.f
design/rcb_pkg.sv
design/rcb_ram.sv
design/rcb_ctrl.sv
design/rcb_datapath.sv
design/rotating_color_key_blitter_top.sv
dv/tb.sv
